// ----- hw/rtl/satc_pkg.sv -----
// ----------------------------------------------------------------------------
// satc_pkg
// Shared types and constants for the set-associative cache tag model.
// ----------------------------------------------------------------------------
package satc_pkg;

   // Geometry; the field widths of the access and result transfers follow from it
   localparam int SETS     = 64;
   localparam int WAYS     = 4;
   localparam int TAG_BITS = 24;

   localparam int SET_W  = $clog2(SETS);
   localparam int WAY_W  = $clog2(WAYS);
   localparam int RANK_W = $clog2(WAYS);

   // Configuration register indexes and widths
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPL_MODE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_ALLOC = 1'd1;

   // Replacement modes; codes at or above random take the supplied way as victim in a full set
   localparam logic [1:0] MODE_LRU    = 2'd0;
   localparam logic [1:0] MODE_RANDOM = 2'd2;

   // Access kinds
   localparam logic KIND_READ = 1'b0;

   typedef struct packed {
      logic                kind;
      logic [SET_W-1:0]    set_index;
      logic [TAG_BITS-1:0] line_tag;
      logic [WAY_W-1:0]    random_way;
   } req_type;

   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] way_used;
      logic             filled;
      logic             evicted;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_wr;   // write one cleared row of the state memory
      logic accept;     // take the access, start the row read
      logic lookup;     // register the hit / victim decision
      logic update;     // write the row back
      logic send;       // load the result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last; // clearing pass is at its last row
      logic rsp_free;   // result register can take a new result
   } status_type;

endpackage

// ----- hw/rtl/satc_ctrl.sv -----
// ----------------------------------------------------------------------------
// satc_ctrl
// Sequencer: clearing pass after reset, then read / decide / write back /
// respond for each access.
// ----------------------------------------------------------------------------
module satc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  satc_pkg::status_type status,
   output satc_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_SEND
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_SEND;
         ST_SEND: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands decoded from state
   assign req_ready    = (state_ff == ST_IDLE);
   assign cmd.clear_wr = (state_ff == ST_CLEAR);
   assign cmd.accept   = (state_ff == ST_IDLE) && req_valid;
   assign cmd.lookup   = (state_ff == ST_LOOKUP);
   assign cmd.update   = (state_ff == ST_UPDATE);
   assign cmd.send     = (state_ff == ST_SEND) && status.rsp_free;

endmodule

// ----- hw/rtl/satc_datapath.sv -----
// ----------------------------------------------------------------------------
// satc_datapath
// Tag and state memories, configuration registers, hit / victim decision,
// rank update and the result register.
// ----------------------------------------------------------------------------
module satc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  satc_pkg::req_type                   req_data,
   input  logic                                csr_valid,
   input  logic [satc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [satc_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output satc_pkg::rsp_type                   rsp_data,
   input  satc_pkg::cmd_type                   cmd,
   output satc_pkg::status_type                status
);

   localparam int WAYS   = satc_pkg::WAYS;
   localparam int WAY_W  = satc_pkg::WAY_W;
   localparam int RANK_W = satc_pkg::RANK_W;
   localparam int SET_W  = satc_pkg::SET_W;

   // Per-set valid bits and ranks, one memory row per set
   typedef struct packed {
      logic [WAYS-1:0]              valid;
      logic [WAYS-1:0][RANK_W-1:0]  rank;
   } meta_type;

   typedef logic [WAYS-1:0][satc_pkg::TAG_BITS-1:0] tag_row_type;

   typedef struct packed {
      logic             hit;
      logic             filled;
      logic             evicted;
      logic [WAY_W-1:0] way;
   } decision_type;

   meta_type    meta_mem [satc_pkg::SETS];
   tag_row_type tag_mem  [satc_pkg::SETS];

   logic [SET_W-1:0]    clr_cnt_ff;
   logic [1:0]          repl_mode_ff;
   logic                write_alloc_ff;
   satc_pkg::req_type   req_ff;
   meta_type            rd_meta_ff;
   tag_row_type         rd_tag_ff;
   decision_type        dec_ff;
   decision_type        dec_in;
   meta_type            meta_in;
   tag_row_type         tag_in;
   logic                rsp_valid_ff;
   satc_pkg::rsp_type   rsp_ff;

   // Configuration registers, written whenever a transfer arrives
   always_ff @(posedge clock) begin
      if (reset) begin
         repl_mode_ff   <= satc_pkg::MODE_LRU;
         write_alloc_ff <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            satc_pkg::CSR_REPL_MODE:   repl_mode_ff   <= csr_data;
            satc_pkg::CSR_WRITE_ALLOC: write_alloc_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Clearing pass row counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   assign status.clear_last = (clr_cnt_ff == SET_W'(satc_pkg::SETS - 1));

   // Memories: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         meta_mem[clr_cnt_ff] <= '0;
      end else if (cmd.update) begin
         meta_mem[req_ff.set_index] <= meta_in;
      end
      if (cmd.update && dec_ff.filled) begin
         tag_mem[req_ff.set_index] <= tag_in;
      end
      if (cmd.accept) begin
         req_ff     <= req_data;
         rd_meta_ff <= meta_mem[req_data.set_index];
         rd_tag_ff  <= tag_mem[req_data.set_index];
      end
   end

   // Lookup: first hitting way, else highest free way, else supplied way (random modes) or oldest way
   always_comb begin
      logic             is_hit;
      logic [WAY_W-1:0] hit_way;
      logic             have_free;
      logic [WAY_W-1:0] free_way;
      logic [RANK_W-1:0] best;
      logic [WAY_W-1:0] old_way;
      logic [WAY_W-1:0] victim;
      logic             do_fill;
      is_hit    = 1'b0;
      hit_way   = '0;
      have_free = 1'b0;
      free_way  = '0;
      best      = '0;
      old_way   = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (rd_meta_ff.valid[w]) begin
            if (!is_hit && rd_tag_ff[w] == req_ff.line_tag) begin
               is_hit  = 1'b1;
               hit_way = WAY_W'(w);
            end
         end else begin
            have_free = 1'b1;
            free_way  = WAY_W'(w);
         end
         if (rd_meta_ff.rank[w] > best) begin
            best    = rd_meta_ff.rank[w];
            old_way = WAY_W'(w);
         end
      end
      priority if (have_free) begin
         victim = free_way;
      end else if (repl_mode_ff >= satc_pkg::MODE_RANDOM) begin
         victim = req_ff.random_way;
      end else begin
         victim = old_way;
      end
      do_fill = !is_hit && (req_ff.kind == satc_pkg::KIND_READ || write_alloc_ff);
      dec_in.hit     = is_hit;
      dec_in.filled  = do_fill;
      dec_in.way     = is_hit ? hit_way : (do_fill ? victim : '0);
      dec_in.evicted = do_fill && rd_meta_ff.valid[victim];
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         dec_ff <= dec_in;
      end
   end

   // Write-back row: on a fill or an LRU hit, age the ways newer than the touched one and make the touched way newest
   always_comb begin
      logic              touch;
      logic [RANK_W:0]   limit;
      touch  = dec_ff.filled || (dec_ff.hit && repl_mode_ff == satc_pkg::MODE_LRU);
      limit  = (dec_ff.filled && !dec_ff.evicted) ? (RANK_W + 1)'(WAYS)
                                                  : {1'b0, rd_meta_ff.rank[dec_ff.way]};
      meta_in = rd_meta_ff;
      tag_in  = rd_tag_ff;
      if (touch) begin
         for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) != dec_ff.way && rd_meta_ff.valid[w]
                && {1'b0, rd_meta_ff.rank[w]} < limit
                && rd_meta_ff.rank[w] < RANK_W'(WAYS - 1)) begin
               meta_in.rank[w] = rd_meta_ff.rank[w] + 1'b1;
            end
         end
         meta_in.rank[dec_ff.way] = '0;
      end
      if (dec_ff.filled) begin
         meta_in.valid[dec_ff.way] = 1'b1;
         tag_in[dec_ff.way]        = req_ff.line_tag;
      end
   end

   // Result register
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.send) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.send) begin
         rsp_ff.hit      <= dec_ff.hit;
         rsp_ff.way_used <= dec_ff.way;
         rsp_ff.filled   <= dec_ff.filled;
         rsp_ff.evicted  <= dec_ff.evicted;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hw/rtl/set_associative_cache_tag_model.sv -----
// ----------------------------------------------------------------------------
// set_associative_cache_tag_model
// Four-way, 64-set cache tag array with LRU, FIFO or random replacement.
// ----------------------------------------------------------------------------
// After reset the block sweeps its per-set valid/rank memory, one set per
// cycle; accesses are held off (req_ready low) until the sweep ends, while
// configuration writes are taken at once. Each access then passes through
// these steps from transfer to result: a registered read of the set's tag and
// state rows, the hit and victim decision, the row write-back, and the load of
// the result register once that register is free. No new access is taken until
// the previous result is loaded, and a loaded result waits in its output
// register without blocking the taking of the next access. Configuration writes
// (csr_ready is always high) are meant for idle periods only.
module set_associative_cache_tag_model (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  satc_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output satc_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [satc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [satc_pkg::CSR_DATA_W-1:0]  csr_data
);

   satc_pkg::cmd_type    cmd;
   satc_pkg::status_type status;

   assign csr_ready = 1'b1;

   satc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   satc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ----- sim/set_associative_cache_tag_model_checker.sv -----
// ----------------------------------------------------------------------------
// set_associative_cache_tag_model_checker
// Watches the access, result and register channels of the cache tag model,
// keeps its own copy of the tag array and ranks, works out the outcome of
// every access transfer and compares it with the result transfers in order.
// ----------------------------------------------------------------------------
module set_associative_cache_tag_model_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  satc_pkg::req_type               req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  satc_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [satc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [satc_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              outstanding,
   output int                              mismatch_total,
   output int                              hits_seen,
   output int                              evictions_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow tag array: valid bit, tag and age rank per way (rank 0 is newest)
   logic                          line_ok  [satc_pkg::SETS][satc_pkg::WAYS];
   logic [satc_pkg::TAG_BITS-1:0] line_tag [satc_pkg::SETS][satc_pkg::WAYS];
   logic [satc_pkg::RANK_W-1:0]   line_age [satc_pkg::SETS][satc_pkg::WAYS];

   logic [1:0]          repl_mode;
   logic                alloc_on_write;

   satc_pkg::rsp_type   outcome_q [$];
   int                  error_count = 0;
   int                  hit_count   = 0;
   int                  evict_count = 0;

   // Age every valid way other than skip whose rank is below limit, saturating
   function automatic void age_newer_ways(int s, int skip, int limit);
      for (int w = 0; w < satc_pkg::WAYS; w++) begin
         if (w != skip && line_ok[s][w] && int'(line_age[s][w]) < limit &&
             int'(line_age[s][w]) < satc_pkg::WAYS - 1)
            line_age[s][w] = line_age[s][w] + 1'b1;
      end
   endfunction

   // Look up one access, update the shadow array and return the outcome
   function automatic satc_pkg::rsp_type resolve_access(satc_pkg::req_type a);
      satc_pkg::rsp_type r;
      int      s;
      int      hit_way;
      int      free_way;
      int      way;
      int      oldest;
      logic    hit_found;
      logic    free_found;
      logic    do_fill;
      logic    was_valid;
      s          = int'(a.set_index);
      hit_found  = 1'b0;
      free_found = 1'b0;
      do_fill    = 1'b0;
      was_valid  = 1'b0;
      hit_way    = 0;
      free_way   = 0;
      way        = 0;
      // first matching valid way wins; last invalid way is the free one
      for (int w = 0; w < satc_pkg::WAYS; w++) begin
         if (line_ok[s][w]) begin
            if (!hit_found && line_tag[s][w] == a.line_tag) begin
               hit_found = 1'b1;
               hit_way   = w;
            end
         end else begin
            free_found = 1'b1;
            free_way   = w;
         end
      end
      if (hit_found) begin
         way = hit_way;
         // only LRU reorders on a hit
         if (repl_mode == satc_pkg::MODE_LRU) begin
            age_newer_ways(s, hit_way, int'(line_age[s][hit_way]));
            line_age[s][hit_way] = '0;
         end
      end else if (a.kind == satc_pkg::KIND_READ || alloc_on_write) begin
         do_fill = 1'b1;
         if (free_found) begin
            way = free_way;
         end else if (repl_mode >= satc_pkg::MODE_RANDOM) begin
            way = int'(a.random_way);
         end else begin
            // oldest rank, lowest way on ties
            oldest = 0;
            for (int w = 0; w < satc_pkg::WAYS; w++) begin
               if (int'(line_age[s][w]) > oldest) begin
                  oldest = int'(line_age[s][w]);
                  way    = w;
               end
            end
         end
         was_valid = line_ok[s][way];
         age_newer_ways(s, way, was_valid ? int'(line_age[s][way]) : satc_pkg::WAYS);
         line_ok[s][way]  = 1'b1;
         line_tag[s][way] = a.line_tag;
         line_age[s][way] = '0;
      end
      r.hit      = hit_found;
      r.way_used = (hit_found || do_fill) ? satc_pkg::WAY_W'(way) : '0;
      r.filled   = do_fill;
      r.evicted  = was_valid;
      return r;
   endfunction

   function automatic void compare_field(string field, logic [1:0] want, logic [1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   // Track transfers on all three channels
   always @(posedge clock) begin
      satc_pkg::rsp_type want;
      if (reset) begin
         foreach (line_ok[s, w]) begin
            line_ok[s][w]  = 1'b0;
            line_age[s][w] = '0;
         end
         repl_mode      = satc_pkg::MODE_LRU;
         alloc_on_write = 1'b1;
         outcome_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == satc_pkg::CSR_REPL_MODE)
               repl_mode = csr_data;
            else if (csr_index == satc_pkg::CSR_WRITE_ALLOC)
               alloc_on_write = csr_data[0];
         end
         if (req_valid && req_ready)
            outcome_q = {outcome_q, resolve_access(req_data)};
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               error_count++;
               $display("%0t ns: result transfer with no access outstanding,", $time);
               $display("   expected none, actual %p", rsp_data);
            end else begin
               want = outcome_q.pop_front();
               if (want.hit)     hit_count++;
               if (want.evicted) evict_count++;
               compare_field("hit",      {1'b0, want.hit},     {1'b0, rsp_data.hit});
               compare_field("way_used", want.way_used,        rsp_data.way_used);
               compare_field("filled",   {1'b0, want.filled},  {1'b0, rsp_data.filled});
               compare_field("evicted",  {1'b0, want.evicted}, {1'b0, rsp_data.evicted});
            end
         end
      end
      outstanding    <= outcome_q.size();
      mismatch_total <= error_count;
      hits_seen      <= hit_count;
      evictions_seen <= evict_count;
   end

endmodule

// ----- sim/set_associative_cache_tag_model_tb.sv -----
// ----------------------------------------------------------------------------
// set_associative_cache_tag_model_tb
// Drives read and write accesses into the cache tag model under every
// replacement mode and both write allocation settings, with bursty traffic
// and a stalling receiver; the checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module set_associative_cache_tag_model_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_FIFO      = 2'd1;
   localparam logic [1:0] MODE_RANDOM_HI = 2'd3;
   localparam logic       KIND_WRITE     = 1'b1;
   localparam logic       WA_OFF         = 1'b0;
   localparam logic       WA_ON          = 1'b1;
   localparam int         RANDOM_ITEMS   = 110;
   localparam int         IDLE_LIMIT     = 1000;
   localparam int         DRAIN_CYCLES   = 20;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   satc_pkg::req_type               req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   satc_pkg::rsp_type               rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [satc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [satc_pkg::CSR_DATA_W-1:0] csr_data  = '0;

   int                    outstanding;
   int                    mismatch_total;
   int                    hits_seen;
   int                    evictions_seen;

   int                    burst_left  = 4;
   int                    read_total  = 0;
   int                    write_total = 0;
   int                    idle_cycles = 0;
   logic [15:0]           ready_pattern = 16'hFFFF;
   logic [5:0]            pattern_age   = '0;
   logic [satc_pkg::SET_W-1:0]    hot_sets [4];
   logic [satc_pkg::TAG_BITS-1:0] hot_tags [6];

   set_associative_cache_tag_model dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   set_associative_cache_tag_model_checker tag_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .outstanding    (outstanding),
      .mismatch_total (mismatch_total),
      .hits_seen      (hits_seen),
      .evictions_seen (evictions_seen)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver: rotating ready pattern, reloaded when the age counter wraps; bit 0 forced
   // so a stall never runs past one pattern length
   always @(posedge clock) begin
      pattern_age <= pattern_age + 1'b1;
      if (pattern_age == '1)
         ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                      : (16'($urandom) | 16'h0001);
      else
         ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
      rsp_ready <= ready_pattern[15];
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                  $time, IDLE_LIMIT, outstanding);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic satc_pkg::req_type make_access(logic kind,
                                                     logic [satc_pkg::SET_W-1:0] set_index,
                                                     logic [satc_pkg::TAG_BITS-1:0] line_tag,
                                                     logic [satc_pkg::WAY_W-1:0] random_way);
      satc_pkg::req_type a;
      a.kind       = kind;
      a.set_index  = set_index;
      a.line_tag   = line_tag;
      a.random_way = random_way;
      return a;
   endfunction

   // Mostly a few hot sets and a small tag pool so sets fill, hit and evict
   function automatic satc_pkg::req_type random_access();
      satc_pkg::req_type a;
      a.kind       = 1'($urandom_range(0, 1));
      a.set_index  = ($urandom_range(0, 9) < 7)
                     ? hot_sets[$urandom_range(0, 3)]
                     : satc_pkg::SET_W'($urandom_range(0, satc_pkg::SETS - 1));
      a.line_tag   = ($urandom_range(0, 9) < 8) ? hot_tags[$urandom_range(0, 5)]
                                                : satc_pkg::TAG_BITS'($urandom);
      a.random_way = satc_pkg::WAY_W'($urandom_range(0, satc_pkg::WAYS - 1));
      return a;
   endfunction

   // One access transfer; valid drops only at the end of a burst
   task automatic send_access(input satc_pkg::req_type item);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (item.kind == KIND_WRITE) write_total++;
      else                         read_total++;
      burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_register(input logic [satc_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [satc_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Registers change only with nothing in flight
   task automatic apply_setting(input logic [1:0] mode,
                                input logic [satc_pkg::CSR_DATA_W-1:0] alloc);
      req_valid <= 1'b0;
      wait_idle();
      write_register(satc_pkg::CSR_REPL_MODE, mode);
      write_register(satc_pkg::CSR_WRITE_ALLOC, alloc);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++)
         send_access(random_access());
   endtask

   initial begin
      hot_sets[0] = '0;
      hot_sets[1] = '1;
      hot_sets[2] = satc_pkg::SET_W'($urandom_range(1, satc_pkg::SETS - 2));
      hot_sets[3] = satc_pkg::SET_W'($urandom_range(1, satc_pkg::SETS - 2));
      hot_tags[0] = '0;
      hot_tags[1] = '1;
      for (int i = 2; i < 6; i++)
         hot_tags[i] = satc_pkg::TAG_BITS'($urandom);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // LRU, write-back
      apply_setting(satc_pkg::MODE_LRU, {1'b0, WA_ON});
      // empty set fills from the highest way down, write miss allocates
      send_access(make_access(satc_pkg::KIND_READ, 6'd0, 24'h000000, 2'd0));
      send_access(make_access(satc_pkg::KIND_READ, 6'd0, 24'hFFFFFF, 2'd3));
      send_access(make_access(KIND_WRITE,          6'd0, 24'h000001, 2'd1));
      send_access(make_access(satc_pkg::KIND_READ, 6'd0, 24'h000002, 2'd2));
      // hits reorder the ranks
      send_access(make_access(satc_pkg::KIND_READ, 6'd0, 24'h000000, 2'd0));
      send_access(make_access(KIND_WRITE,          6'd0, 24'hFFFFFF, 2'd0));
      // full set evicts the least recently used way
      send_access(make_access(satc_pkg::KIND_READ, 6'd0, 24'h000003, 2'd3));
      send_access(make_access(satc_pkg::KIND_READ, 6'd0, 24'h000001, 2'd0));
      // top set, alternating tag bits
      send_access(make_access(satc_pkg::KIND_READ, 6'd63, 24'h555555, 2'd1));
      send_access(make_access(KIND_WRITE,          6'd63, 24'hAAAAAA, 2'd2));
      send_access(make_access(satc_pkg::KIND_READ, 6'd63, 24'h555555, 2'd0));
      send_access(make_access(KIND_WRITE,          6'd63, 24'hAAAAAA, 2'd3));
      send_access(make_access(KIND_WRITE,          6'd63, 24'h000000, 2'd0));
      send_access(make_access(satc_pkg::KIND_READ, 6'd63, 24'hFFFFFF, 2'd1));
      send_access(make_access(satc_pkg::KIND_READ, 6'd63, 24'h123456, 2'd2));
      send_random(RANDOM_ITEMS);

      // FIFO, write-through: a write miss leaves the set alone
      apply_setting(MODE_FIFO, {1'b0, WA_OFF});
      send_access(make_access(KIND_WRITE,          6'd0, 24'h00ABCD, 2'd0));
      send_access(make_access(satc_pkg::KIND_READ, 6'd0, 24'h00ABCD, 2'd0));
      send_random(RANDOM_ITEMS);

      // random victim, write-back set through the upper data bit too
      apply_setting(satc_pkg::MODE_RANDOM, {1'b1, WA_ON});
      send_random(RANDOM_ITEMS);

      // mode three acts as random
      apply_setting(MODE_RANDOM_HI, {1'b1, WA_OFF});
      send_random(RANDOM_ITEMS);

      // back to LRU on ranks left by the random modes
      apply_setting(satc_pkg::MODE_LRU, {1'b0, WA_ON});
      send_random(RANDOM_ITEMS);

      req_valid <= 1'b0;
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d reads and %0d writes under LRU, FIFO, random and mode 3,",
               read_total, write_total);
      $display("with write allocation on and off: %0d hits, %0d evictions.",
               hits_seen, evictions_seen);
      if (mismatch_total == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/satc_pkg.sv
hw/rtl/satc_ctrl.sv
hw/rtl/satc_datapath.sv
hw/rtl/set_associative_cache_tag_model.sv
sim/set_associative_cache_tag_model_checker.sv
sim/set_associative_cache_tag_model_tb.sv
